@@ hw/rtl/mh64_pkg.sv @@
// ----------------------------------------------------------------------------
// mh64_pkg: shared types and constants for the 64-bit Murmur byte hash
// Multiplier constant, operation codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam logic [31:0] MUR_MUL_HI = 32'hc6a4a793;
  localparam logic [31:0] MUR_MUL_LO = 32'h5bd1e995;
  localparam int          MUR_SHIFT  = 47;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

  // datapath operation codes; each one is a single multiply by the constant
  localparam logic [2:0] OP_INIT = 3'd0;  // h = seed ^ (len * M)
  localparam logic [2:0] OP_PRE1 = 3'd1;  // x = xs47(x * M)
  localparam logic [2:0] OP_PRE2 = 3'd2;  // x = x * M
  localparam logic [2:0] OP_FOLD = 3'd3;  // h = (h ^ x) * M
  localparam logic [2:0] OP_FIN  = 3'd4;  // out = xs47(xs47(h) * M)

  typedef struct packed {
    logic       accept;     // take the input transaction
    logic       mul_start;  // capture partial products
    logic       wb;         // sum partials and write back
    logic [2:0] op;
  } mh64_cmd_t;

  typedef struct packed {
    logic in_first;   // flags of the word on the input port
    logic in_full;
    logic in_nz;
    logic in_last;
    logic full;       // flags of the word held in the datapath
    logic nz;
    logic last;
    logic out_free;   // result register can take a new hash
  } mh64_status_t;

endpackage

@@ hw/rtl/mh64_ctrl.sv @@
// ----------------------------------------------------------------------------
// mh64_ctrl: sequencer for the Murmur hash datapath
// Steps one word through its multiplies, each a capture state and a write-back state.
// ----------------------------------------------------------------------------
module mh64_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mh64_pkg::mh64_status_t status,
  output mh64_pkg::mh64_cmd_t    cmd
);
  import mh64_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INIT_A = 4'd1;
  localparam logic [3:0] ST_INIT_B = 4'd2;
  localparam logic [3:0] ST_PRE1_A = 4'd3;
  localparam logic [3:0] ST_PRE1_B = 4'd4;
  localparam logic [3:0] ST_PRE2_A = 4'd5;
  localparam logic [3:0] ST_PRE2_B = 4'd6;
  localparam logic [3:0] ST_FOLD_A = 4'd7;
  localparam logic [3:0] ST_FOLD_B = 4'd8;
  localparam logic [3:0] ST_FIN_A  = 4'd9;
  localparam logic [3:0] ST_FIN_B  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // work left once the starting hash is set up
  function automatic logic [3:0] after_init(input logic full, input logic nz,
                                            input logic last);
    logic [3:0] s;
    if (full) begin
      s = ST_PRE1_A;
    end else if (nz) begin
      s = ST_FOLD_A;
    end else if (last) begin
      s = ST_FIN_A;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_INIT;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = status.in_first ? ST_INIT_A
                     : after_init(status.in_full, status.in_nz, status.in_last);
        end
      end
      ST_INIT_A: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_INIT_B;
      end
      ST_INIT_B: begin
        cmd.wb     = 1'b1;
        state_next = after_init(status.full, status.nz, status.last);
      end
      ST_PRE1_A: begin
        cmd.op        = OP_PRE1;
        cmd.mul_start = 1'b1;
        state_next    = ST_PRE1_B;
      end
      ST_PRE1_B: begin
        cmd.op     = OP_PRE1;
        cmd.wb     = 1'b1;
        state_next = ST_PRE2_A;
      end
      ST_PRE2_A: begin
        cmd.op        = OP_PRE2;
        cmd.mul_start = 1'b1;
        state_next    = ST_PRE2_B;
      end
      ST_PRE2_B: begin
        cmd.op     = OP_PRE2;
        cmd.wb     = 1'b1;
        state_next = ST_FOLD_A;
      end
      ST_FOLD_A: begin
        cmd.op        = OP_FOLD;
        cmd.mul_start = 1'b1;
        state_next    = ST_FOLD_B;
      end
      ST_FOLD_B: begin
        cmd.op     = OP_FOLD;
        cmd.wb     = 1'b1;
        state_next = status.last ? ST_FIN_A : ST_IDLE;
      end
      ST_FIN_A: begin
        cmd.op        = OP_FIN;
        cmd.mul_start = 1'b1;
        state_next    = ST_FIN_B;
      end
      ST_FIN_B: begin
        // hold the partials until the result register frees up
        cmd.op = OP_FIN;
        if (status.out_free) begin
          cmd.wb     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/mh64_datapath.sv @@
// ----------------------------------------------------------------------------
// mh64_datapath: Murmur hash registers and shared constant multiplier
// 64x64 constant multiply split into three 32x32 partials, summed at write-back.
// ----------------------------------------------------------------------------
module mh64_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  mh64_pkg::mh64_cmd_t    cmd,
  output mh64_pkg::mh64_status_t status,
  input  logic                   cfg_we,
  input  logic [63:0]            cfg_wdata,
  input  logic [63:0]            data_word,
  input  logic [3:0]             valid_bytes,
  input  logic                   first_word,
  input  logic                   last_word,
  input  logic [31:0]            message_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            hash_value
);
  import mh64_pkg::*;

  logic [63:0] seed;
  logic [63:0] running_hash;
  logic [63:0] x;
  logic [31:0] len;
  logic        full, nz, last;
  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;

  logic        in_full;
  logic [63:0] in_masked;
  logic [63:0] opnd;
  logic [63:0] ll_prod;
  logic [31:0] lh_prod;
  logic [31:0] hl_prod;
  logic [63:0] prod;

  function automatic logic [63:0] xs47(input logic [63:0] v);
    return v ^ (v >> MUR_SHIFT);
  endfunction

  assign in_full = (valid_bytes >= WORD_BYTES);

  // keep only the valid low bytes of a short word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_masked[8*i +: 8] = (in_full || (4'(i) < valid_bytes)) ? data_word[8*i +: 8]
                                                               : 8'h00;
    end
  end

  always_comb begin
    case (cmd.op)
      OP_INIT: opnd = {32'b0, len};
      OP_FOLD: opnd = running_hash ^ x;
      OP_FIN:  opnd = xs47(running_hash);
      default: opnd = x;
    endcase
  end

  // a*M mod 2^64 = aL*ML + ((aL*MH + aH*ML) << 32)
  assign ll_prod = opnd[31:0] * MUR_MUL_LO;
  assign lh_prod = opnd[31:0] * MUR_MUL_HI;
  assign hl_prod = opnd[63:32] * MUR_MUL_LO;
  assign prod    = p_ll + {p_lh + p_hl, 32'b0};

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      p_ll <= ll_prod;
      p_lh <= lh_prod;
      p_hl <= hl_prod;
    end
    if (cmd.accept) begin
      x     <= in_masked;
      len   <= message_length;
      full  <= in_full;
      nz    <= (valid_bytes != 4'd0);
      last  <= last_word;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_PRE1: x <= xs47(prod);
        OP_PRE2: x <= prod;
        OP_FIN:  hash_value <= xs47(prod);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      // a new hash replaces one taken at the same edge
      if (cmd.wb && cmd.op == OP_FIN) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.wb) begin
        case (cmd.op)
          OP_INIT: running_hash <= seed ^ prod;
          OP_FOLD: running_hash <= prod;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    status.in_first = first_word;
    status.in_full  = in_full;
    status.in_nz    = (valid_bytes != 4'd0);
    status.in_last  = last_word;
    status.full     = full;
    status.nz       = nz;
    status.last     = last;
    status.out_free = !out_valid || out_ready;
  end

endmodule

@@ hw/rtl/murmur2_64_byte_hash_core.sv @@
// ----------------------------------------------------------------------------
// murmur2_64_byte_hash_core: 64-bit Murmur hash of a streamed byte message
// Per word: an accept step, then a capture and a sum step per constant multiply
//   on the shared multiplier: +1 multiply for a first word, +3 for a full
//   word, +1 for a tail, +1 for a last word.
// Result: registered, out_valid is set by the finalize write-back.
// Reset (rst, synchronous): controller idle, seed and running hash zero.
// ----------------------------------------------------------------------------
module murmur2_64_byte_hash_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: seed register
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] message_length,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);
  import mh64_pkg::*;

  // Controller walks each word through its multiply sequence:
  //   first word   : init (h = seed ^ len*M)
  //   full word    : premix (two multiplies), then fold
  //   tail 1..7    : fold of the masked bytes
  //   last word    : finalize into the result register
  // Each multiply is a capture step (three 32x32 partials) and a sum step
  // with write-back. Only one word is in flight at a time.
  mh64_cmd_t    cmd;
  mh64_status_t status;

  mh64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds the seed, the running hash, the premix word and the
  // result register; the result register lets the finalize step wait
  // until a pending hash has been taken.
  mh64_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hash_value     (hash_value)
  );

  // one word at a time: a transaction with work to do closes the input side
  // (an empty word that neither starts nor ends a message is done at once)
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (status.in_first || status.in_nz || status.in_last)
    |=> !in_ready)
    else $error("input accepted while a word is still in progress");

  // every partial-product capture is followed by the write-back state of the same operation
  a_mul_pairs: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> (cmd.wb || cmd.op == OP_FIN) && cmd.op == $past(cmd.op))
    else $error("multiply capture not followed by its write-back");

  // a new result comes only from a finalize write-back
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.wb && cmd.op == OP_FIN))
    else $error("result raised without finalize");

endmodule

@@ test/murmur2_64_byte_hash_core_tb.sv @@
// ----------------------------------------------------------------------------
// murmur2_64_byte_hash_core_tb: self-checking bench for the 64-bit Murmur core
// Streams a directed table, then random messages under several seeds, through
// the word port. The sender works in bursts and the receiver stalls on its own
// pattern. Every finished hash is checked against an in-bench predictor or a hand-written hash.
// ----------------------------------------------------------------------------
module murmur2_64_byte_hash_core_tb;
  import mh64_pkg::*;

  // Full 64-bit multiplier, built from the package halves.
  localparam logic [63:0] HASH_MUL = {MUR_MUL_HI, MUR_MUL_LO};

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  // Leave a wide margin before a seed write so a word that yields no hash
  // has surely left the datapath.
  localparam int DRAIN_CYCLES = 32;
  localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
  localparam int PHASE_ITEMS  = 310;     // random words per seed setting
  localparam int NUM_PHASES   = 6;
  localparam int CYCLE_LIMIT  = 400000;  // watchdog
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_DIRECTED = 20;

  // One word transaction as seen on the input port.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        is_first;
    logic        is_last;
    logic [31:0] msg_len;
  } hash_word_t;

  // Directed table row: a word plus an optional hand-written hash.
  typedef struct packed {
    hash_word_t  word;
    logic        known;
    logic [63:0] known_hash;
  } dir_row_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_we         = 1'b0;
  logic [63:0] cfg_wdata      = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [63:0] data_word      = '0;
  logic [3:0]  valid_bytes    = '0;
  logic        first_word     = 1'b0;
  logic        last_word      = 1'b0;
  logic [31:0] message_length = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [63:0] hash_value;

  murmur2_64_byte_hash_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hash_value     (hash_value)
  );

  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state and the store of hashes still owed by the core.
  // --------------------------------------------------------------------------
  logic [63:0] seed_model = '0;
  logic [63:0] run_hash   = '0;
  logic [63:0] hash_q [$];

  int          error_count  = 0;
  int          words_sent   = 0;
  int          burst_left   = 0;
  int          hold_req_cnt = 0;  // bumped by stimulus to ask for a hold-off
  int          cycle_count  = 0;

  dir_row_t    dir_table [NUM_DIRECTED];

  // Fold one accepted word into the running hash. Finalization only feeds
  // the digest; run_hash keeps the unfinalized value across messages.
  task automatic absorb_word(input hash_word_t w, output bit done,
                             output logic [63:0] digest);
    logic [63:0] x;
    logic [3:0]  n;
    if (w.is_first)
      run_hash = seed_model ^ ({32'd0, w.msg_len} * HASH_MUL);
    // counts above eight behave as a full word
    n = (w.nbytes > WORD_BYTES) ? WORD_BYTES : w.nbytes;
    if (n == WORD_BYTES) begin
      x = w.data * HASH_MUL;
      x = x ^ (x >> MUR_SHIFT);
      x = x * HASH_MUL;
      run_hash = (run_hash ^ x) * HASH_MUL;
    end else if (n != 4'd0) begin
      // tail: only the valid low bytes, no premix
      x = w.data & ((64'd1 << (8 * n)) - 64'd1);
      run_hash = (run_hash ^ x) * HASH_MUL;
    end
    done = w.is_last;
    x = run_hash ^ (run_hash >> MUR_SHIFT);
    x = x * HASH_MUL;
    digest = x ^ (x >> MUR_SHIFT);
  endtask

  task automatic report_fail(input string what, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR %s: expected %h got %h (cycle %0d)", what, exp_v, got_v,
               cycle_count);
  endtask

  // Drive one word and hold it until the core takes it. The sender runs in
  // bursts; valid drops only between bursts, never between two back-to-back
  // transactions.
  task automatic send_word(input hash_word_t w, input bit known,
                           input logic [63:0] known_hash);
    int          gap;
    bit          done;
    logic [63:0] digest;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid       <= 1'b1;
    data_word      <= w.data;
    valid_bytes    <= w.nbytes;
    first_word     <= w.is_first;
    last_word      <= w.is_last;
    message_length <= w.msg_len;
    do @(posedge clk); while (!in_ready);
    // transaction accepted at this edge
    absorb_word(w, done, digest);
    if (done)
      hash_q.push_back(known ? known_hash : digest);
    words_sent++;
  endtask

  // Seed writes only with the core idle: no hash owed and the datapath empty.
  task automatic write_seed(input logic [63:0] value);
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    seed_model  = value;
    burst_left  = 0;
  endtask

  // One random message. Mostly well-formed with random content; the rest is
  // single noise words and broken messages (cut short, stray tails, empties).
  task automatic send_message();
    int         kind;
    int         pick;
    int         len;
    int         nfull;
    int         tail;
    int         total;
    int         cut;
    bit         broken;
    logic [31:0] len_field;
    hash_word_t w;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      w.data     = {$urandom, $urandom};
      w.nbytes   = 4'($urandom_range(0, 15));
      w.is_first = 1'($urandom_range(0, 1));
      w.is_last  = 1'($urandom_range(0, 1));
      w.msg_len  = $urandom;
      send_word(w, 1'b0, '0);
    end else begin
      broken = (kind < 24);
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(0, 32);
      else if (pick < 95) len = $urandom_range(33, 120);
      else                len = $urandom_range(121, 400);
      // length is not checked by the core; sometimes send a mismatch
      len_field = ($urandom_range(0, 9) == 0) ? $urandom : len;
      nfull = len / 8;
      tail  = len % 8;
      total = nfull + ((tail != 0) ? 1 : 0);
      if (total == 0) total = 1;  // empty message: one word of zero bytes
      cut = broken ? $urandom_range(1, total) : total;
      for (int i = 0; i < cut; i++) begin
        w.data     = {$urandom, $urandom};
        w.nbytes   = (i < nfull) ? 4'd8 : 4'(tail);
        w.is_first = (i == 0);
        w.is_last  = (i == total - 1);
        w.msg_len  = (i == 0) ? len_field : $urandom;
        if (w.nbytes == 4'd8 && $urandom_range(0, 15) == 0)
          w.nbytes = 4'($urandom_range(9, 15));
        if (broken) begin
          if ($urandom_range(0, 3) == 0) w.nbytes = 4'($urandom_range(0, 7));
          if (i == cut - 1) w.is_last = 1'($urandom_range(0, 1));
        end
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  function automatic dir_row_t mk_row(logic [63:0] data, logic [3:0] nbytes,
                                      logic is_first, logic is_last,
                                      logic [31:0] msg_len, logic known,
                                      logic [63:0] known_hash);
    dir_row_t r;
    r.word.data     = data;
    r.word.nbytes   = nbytes;
    r.word.is_first = is_first;
    r.word.is_last  = is_last;
    r.word.msg_len  = msg_len;
    r.known         = known;
    r.known_hash    = known_hash;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request so the
  // result register fills and the core backs up its input.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       hold_seen = 0;
  int       rx_tick   = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mode_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen <= hold_req_cnt;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'(2'($urandom_range(0, 3)));
        mode_left <= $urandom_range(64, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick % 13) < 9;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each hash transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [63:0] exp_hash;
    if (!rst && out_valid && out_ready) begin
      if (hash_q.size() == 0) begin
        report_fail("unexpected hash", '0, hash_value);
      end else begin
        exp_hash = hash_q.pop_front();
        if (hash_value !== exp_hash)
          report_fail("hash_value", exp_hash, hash_value);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("murmur2_64_byte_hash_core_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] seed_v;
    int          target;

    // Directed table, seed 0 from reset. Hand-written hashes only where the
    // running hash is plainly zero: finalizing zero gives zero.
    dir_table[0]  = mk_row(64'h0, 4'd0, 1'b1, 1'b1, 32'd0, 1'b1, 64'h0);      // empty msg
    dir_table[1]  = mk_row('1, 4'd0, 1'b0, 1'b1, '1, 1'b1, 64'h0);            // no start, empty
    dir_table[2]  = mk_row('1, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, '0);            // all ones
    dir_table[3]  = mk_row(64'h0, 4'd8, 1'b1, 1'b1, 32'd8, 1'b0, '0);         // all zeros
    dir_table[4]  = mk_row('1, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, '0);            // 1-byte tail
    dir_table[5]  = mk_row('1, 4'd7, 1'b1, 1'b1, 32'd7, 1'b0, '0);            // 7-byte tail
    dir_table[6]  = mk_row(64'h0123456789abcdef, 4'd15, 1'b1, 1'b1, 32'd8, 1'b0, '0);
    dir_table[7]  = mk_row(64'hfedcba9876543210, 4'd9, 1'b1, 1'b1, 32'd8, 1'b0, '0);
    // tail ahead of a full word, then continuation without a start mark
    dir_table[8]  = mk_row(64'hdeadbeefcafef00d, 4'd3, 1'b1, 1'b0, 32'd11, 1'b0, '0);
    dir_table[9]  = mk_row(64'h8000000000000001, 4'd8, 1'b0, 1'b1, 32'd11, 1'b0, '0);
    dir_table[10] = mk_row(64'h5555aaaa5555aaaa, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, '0);
    // length field at its top, unrelated to the words
    dir_table[11] = mk_row(64'haaaa5555aaaa5555, 4'd8, 1'b1, 1'b1, '1, 1'b0, '0);
    // three-word message, 20 bytes
    dir_table[12] = mk_row(64'h0706050403020100, 4'd8, 1'b1, 1'b0, 32'd20, 1'b0, '0);
    dir_table[13] = mk_row(64'h0f0e0d0c0b0a0908, 4'd8, 1'b0, 1'b0, '1, 1'b0, '0);
    dir_table[14] = mk_row(64'hffffffff13121110, 4'd4, 1'b0, 1'b1, 32'd0, 1'b0, '0);
    // empty word in the middle of a message
    dir_table[15] = mk_row(64'h1111111111111111, 4'd8, 1'b1, 1'b0, 32'd16, 1'b0, '0);
    dir_table[16] = mk_row('1, 4'd0, 1'b0, 1'b0, 32'd16, 1'b0, '0);
    dir_table[17] = mk_row(64'h2222222222222222, 4'd8, 1'b0, 1'b1, 32'd16, 1'b0, '0);
    // a new start mark cuts an unfinished message
    dir_table[18] = mk_row(64'h3333333333333333, 4'd8, 1'b1, 1'b0, 32'd24, 1'b0, '0);
    dir_table[19] = mk_row(64'h4444444444444444, 4'd5, 1'b1, 1'b1, 32'd5, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(dir_table[i].word, dir_table[i].known, dir_table[i].known_hash);

    // Random part: one phase per seed setting, extremes included.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       seed_v = '1;
        1:       seed_v = {$urandom, $urandom};
        2:       seed_v = 64'h1;
        3:       seed_v = 64'h8000000000000000;
        4:       seed_v = '0;
        default: seed_v = {$urandom, $urandom};
      endcase
      write_seed(seed_v);
      // long receiver hold-off while the sender keeps offering words
      if (p == 1) hold_req_cnt++;
      target = words_sent + PHASE_ITEMS;
      while (words_sent < target) send_message();
    end

    // Drain: every owed hash back, then the drain margin once more.
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (hash_q.size() != 0)
      report_fail("missing hash", hash_q.pop_front(), '0);

    if (error_count == 0)
      $display("murmur2_64_byte_hash_core_tb passed");
    else
      $display("murmur2_64_byte_hash_core_tb failed");
    $finish;
  end

endmodule
